/* hw/rtl/ssc_pkg.sv */
// Shared constants, types and byte fold function for the substring search block.
package ssc_pkg;

    localparam int NEEDLE_MAX_DEF  = 16;
    localparam int OFFSET_BITS_DEF = 32;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CASE_FOLD     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_LOW    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_HIGH   = 2'd3;

    localparam logic [7:0] UPPER_FIRST = 8'h41;  // 'A'
    localparam logic [7:0] UPPER_LAST  = 8'h5A;  // 'Z'
    localparam logic [7:0] FOLD_DELTA  = 8'h20;  // 'a' - 'A'

    // Control shared by every window cell
    typedef struct packed {
        logic accept;
        logic fold;
    } t_cell_ctl;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
        if (en && (b >= UPPER_FIRST) && (b <= UPPER_LAST)) begin
            return b + FOLD_DELTA;
        end
        return b;
    endfunction

endpackage

/* hw/rtl/ssc_cell.sv */
// One window cell: holds one haystack byte, shifts it on, compares the incoming byte.
module ssc_cell (
    input  logic                i_clk,
    input  ssc_pkg::t_cell_ctl  i_ctl,
    input  logic                i_active,
    input  logic [7:0]          i_needle_byte,
    input  logic [7:0]          i_byte,
    output logic [7:0]          o_byte,
    output logic                o_hit
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    // Stale bytes never reach a compare: the byte count gates every match.
    assign n_byte = i_ctl.accept ? i_byte : r_byte;

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;
    assign o_hit  = !i_active ||
                    (ssc_pkg::fold_byte(i_byte, i_ctl.fold) ==
                     ssc_pkg::fold_byte(i_needle_byte, i_ctl.fold));

endmodule

/* hw/rtl/substring_search_case_fold.sv */
// Top level: config registers, window cell chain, byte count and result register.
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_data_byte, i_last_byte
//  out     | output    | o_out_valid / i_out_ready | o_found, o_match_offset, o_too_long
//  cfg     | input     | i_cfg_wr_en               | i_cfg_index, i_cfg_data
//
// One byte per cycle; the result appears the cycle after the last byte is taken.
// Each cell compares its incoming byte in the same cycle it shifts, so the
// window compare is one parallel pass through the cell row.
// While a result word waits and the output is not ready, every input byte is held
// off; a result taken in the same cycle frees the input at once.
// Reset is synchronous and clears config, count, match state and the result valid
// flag; window bytes are not reset.
module substring_search_case_fold #(
    parameter int NEEDLE_MAX  = ssc_pkg::NEEDLE_MAX_DEF,
    parameter int OFFSET_BITS = ssc_pkg::OFFSET_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_last_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_found,
    output logic [31:0]                     o_match_offset,
    output logic                            o_too_long,
    input  logic                            i_cfg_wr_en,
    input  logic [ssc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int LEN_W = $clog2(NEEDLE_MAX + 1);
    localparam int IDX_W = $clog2(NEEDLE_MAX);
    localparam int CMP_W = (LEN_W > 5) ? LEN_W : 5;
    localparam int NB    = NEEDLE_MAX * 8;

    // configuration
    logic [4:0]  r_needle_length;
    logic        r_case_fold;
    logic [63:0] r_needle_low;
    logic [63:0] r_needle_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_length <= '0;
            r_case_fold     <= 1'b0;
            r_needle_low    <= '0;
            r_needle_high   <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ssc_pkg::CFG_NEEDLE_LENGTH: r_needle_length <= i_cfg_data[4:0];
                ssc_pkg::CFG_CASE_FOLD:     r_case_fold     <= i_cfg_data[0];
                ssc_pkg::CFG_NEEDLE_LOW:    r_needle_low    <= i_cfg_data;
                ssc_pkg::CFG_NEEDLE_HIGH:   r_needle_high   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped needle length
    logic [CMP_W-1:0] w_len_wide;
    logic [CMP_W-1:0] w_len_clamp;
    logic [LEN_W-1:0] w_len;

    assign w_len_wide  = CMP_W'(r_needle_length);
    assign w_len_clamp = (w_len_wide > CMP_W'(NEEDLE_MAX)) ? CMP_W'(NEEDLE_MAX) : w_len_wide;
    assign w_len       = w_len_clamp[LEN_W-1:0];

    // needle bytes past the two registers read as zero
    logic [NB+127:0] w_needle_full;
    logic [7:0]      w_needle_byte [NEEDLE_MAX];

    assign w_needle_full = {{NB{1'b0}}, r_needle_high, r_needle_low};

    // handshake
    logic r_out_valid;
    logic w_accept;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    ssc_pkg::t_cell_ctl w_ctl;
    assign w_ctl.accept = w_accept;
    assign w_ctl.fold   = r_case_fold;

    // cell row, cell 0 takes the newest byte
    logic [7:0]            w_chain [NEEDLE_MAX];
    logic [NEEDLE_MAX-1:0] w_hit;

    assign w_chain[0] = i_data_byte;

    for (genvar k = 0; k < NEEDLE_MAX; k++) begin : g_cell
        logic             w_active;
        logic [LEN_W-1:0] w_pos;

        assign w_needle_byte[k] = w_needle_full[8*k +: 8];
        assign w_active = LEN_W'(k) < w_len;
        // cell k lines up with needle byte len-1-k
        assign w_pos    = w_len - LEN_W'(1) - LEN_W'(k);

        if (k < NEEDLE_MAX - 1) begin : g_mid
            ssc_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_active      (w_active),
                .i_needle_byte (w_needle_byte[w_pos[IDX_W-1:0]]),
                .i_byte        (w_chain[k]),
                .o_byte        (w_chain[k+1]),
                .o_hit         (w_hit[k])
            );
        end else begin : g_end
            ssc_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_active      (w_active),
                .i_needle_byte (w_needle_byte[w_pos[IDX_W-1:0]]),
                .i_byte        (w_chain[k]),
                .o_byte        (),
                .o_hit         (w_hit[k])
            );
        end
    end

    // byte count and match tracking
    logic [OFFSET_BITS-1:0] r_seen;
    logic                   r_sat;
    logic                   r_match;
    logic [OFFSET_BITS-1:0] r_first;

    logic [OFFSET_BITS-1:0] n_seen;
    logic                   n_sat;
    logic                   n_match;
    logic [OFFSET_BITS-1:0] n_first;
    logic                   w_len_zero;
    logic                   w_new_hit;

    assign w_len_zero = (w_len == '0);

    always_comb begin
        n_sat   = r_sat || (r_seen == '1);
        n_seen  = (r_seen == '1) ? r_seen : r_seen + OFFSET_BITS'(1);
        n_match = r_match;
        n_first = r_first;
        w_new_hit = !n_sat && !r_match && !w_len_zero &&
                    (n_seen >= OFFSET_BITS'(w_len)) && (&w_hit);
        if (w_new_hit) begin
            n_match = 1'b1;
            n_first = n_seen - OFFSET_BITS'(w_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_sat   <= 1'b0;
            r_match <= 1'b0;
            r_first <= '0;
        end else if (w_accept) begin
            if (i_last_byte) begin
                r_seen  <= '0;
                r_sat   <= 1'b0;
                r_match <= 1'b0;
                r_first <= '0;
            end else begin
                r_seen  <= n_seen;
                r_sat   <= n_sat;
                r_match <= n_match;
                r_first <= n_first;
            end
        end
    end

    // result register
    logic [OFFSET_BITS+31:0] w_first_ext;
    logic                    r_found;
    logic [31:0]             r_offset;
    logic                    r_too_long;

    assign w_first_ext = {32'd0, n_first};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && i_last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_last_byte) begin
            r_found    <= w_len_zero || n_match;
            r_offset   <= (!w_len_zero && n_match) ? w_first_ext[31:0] : 32'd0;
            r_too_long <= n_sat;
        end
    end

    assign o_found        = r_found;
    assign o_match_offset = r_offset;
    assign o_too_long     = r_too_long;

endmodule

/* sim/substring_search_case_fold_tb.sv */
// Self-checking testbench for the case-folding substring search block.
module substring_search_case_fold_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NEEDLE_MAX    = ssc_pkg::NEEDLE_MAX_DEF;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 680;
    localparam int STEADY_ITEMS  = 120;

    typedef struct packed {
        logic        found;
        logic [31:0] offset;
        logic        too_long;
    } t_search_result;

    logic                            i_clk          = 1'b0;
    logic                            i_rst_n        = 1'b0;
    logic                            i_in_valid     = 1'b0;
    logic                            o_in_ready;
    logic [7:0]                      i_data_byte    = '0;
    logic                            i_last_byte    = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_ready    = 1'b0;
    logic                            o_found;
    logic [31:0]                     o_match_offset;
    logic                            o_too_long;
    logic                            i_cfg_wr_en    = 1'b0;
    logic [ssc_pkg::CFG_INDEX_W-1:0] i_cfg_index    = '0;
    logic [ssc_pkg::CFG_DATA_W-1:0]  i_cfg_data     = '0;

    // local copy of the search configuration and haystack state
    logic [4:0]  cfg_len  = '0;
    logic        cfg_fold = 1'b0;
    logic [63:0] cfg_low  = '0;
    logic [63:0] cfg_high = '0;
    logic [7:0]  recent [NEEDLE_MAX];
    logic [31:0] seen_count;
    logic        hit_seen;
    logic [31:0] hit_start;
    logic        count_full;

    t_search_result expected_q [$];

    int fail_count  = 0;
    int cycle_count = 0;
    int items_sent  = 0;
    int hold_req    = 0;
    bit src_idle    = 1'b0;
    bit snk_idle    = 1'b0;

    substring_search_case_fold u_top (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    function automatic logic [7:0] lower_if_upper(input logic [7:0] b);
        if (cfg_fold && b >= ssc_pkg::UPPER_FIRST && b <= ssc_pkg::UPPER_LAST) begin
            return b + ssc_pkg::FOLD_DELTA;
        end
        return b;
    endfunction

    function automatic logic [7:0] needle_at(input int i);
        if (i < 8) begin
            return cfg_low[8*i +: 8];
        end
        if (i < 16) begin
            return cfg_high[8*(i-8) +: 8];
        end
        return 8'h00;
    endfunction

    function automatic int needle_span();
        return (cfg_len > NEEDLE_MAX) ? NEEDLE_MAX : int'(cfg_len);
    endfunction

    function automatic void clear_haystack();
        foreach (recent[k]) recent[k] = 8'h00;
        seen_count = '0;
        hit_seen   = 1'b0;
        hit_start  = '0;
        count_full = 1'b0;
    endfunction

    function automatic void search_step(input logic [7:0] b, input logic last);
        int             span;
        bit             hit;
        t_search_result res;
        span = needle_span();
        for (int k = NEEDLE_MAX - 1; k > 0; k--) recent[k] = recent[k-1];
        recent[0] = b;
        if (seen_count == '1) begin
            count_full = 1'b1;
        end else begin
            seen_count = seen_count + 1;
        end
        if (!count_full && !hit_seen && span > 0 && seen_count >= span) begin
            hit = 1'b1;
            for (int k = 0; k < span; k++) begin
                if (lower_if_upper(recent[span-1-k]) != lower_if_upper(needle_at(k))) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                hit_seen  = 1'b1;
                hit_start = seen_count - span;
            end
        end
        if (last) begin
            res.found    = (span == 0) || hit_seen;
            res.offset   = (span != 0 && hit_seen) ? hit_start : '0;
            res.too_long = count_full;
            expected_q.push_back(res);
            clear_haystack();
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            search_step(i_data_byte, i_last_byte);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_search_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                $error("result word with none expected: found %0d offset %0d too_long %0d",
                       o_found, o_match_offset, o_too_long);
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                if (o_found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_found);
                    fail_count++;
                end
                if (o_match_offset !== want.offset) begin
                    $error("match_offset: expected %0d, got %0d", want.offset, o_match_offset);
                    fail_count++;
                end
                if (o_too_long !== want.too_long) begin
                    $error("too_long: expected %0d, got %0d", want.too_long, o_too_long);
                    fail_count++;
                end
            end
        end
    end

    // output side pacing; a long hold-off is requested through hold_req
    initial begin : sink_pacing
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                n        = hold_req;
                hold_req = 0;
                i_out_ready <= 1'b0;
                repeat (n - 1) @(posedge i_clk);
            end else if (snk_idle && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 12);
                i_out_ready <= 1'b0;
                repeat (n - 1) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // valid stays high after a word is taken, so back-to-back calls keep streaming
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (src_idle && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k], k == s.len() - 1);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [ssc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [ssc_pkg::CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            ssc_pkg::CFG_NEEDLE_LENGTH: cfg_len  = val[4:0];
            ssc_pkg::CFG_CASE_FOLD:     cfg_fold = val[0];
            ssc_pkg::CFG_NEEDLE_LOW:    cfg_low  = val;
            ssc_pkg::CFG_NEEDLE_HIGH:   cfg_high = val;
            default: ;
        endcase
    endtask

    // unused upper bits of the narrow registers carry random junk
    task automatic load_search(input int len, input bit fold,
                               input logic [63:0] lo, input logic [63:0] hi);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        cfg_write(ssc_pkg::CFG_NEEDLE_LENGTH, {junk[63:5], 5'(len)});
        junk = {$urandom, $urandom};
        cfg_write(ssc_pkg::CFG_CASE_FOLD, {junk[63:1], fold});
        cfg_write(ssc_pkg::CFG_NEEDLE_LOW, lo);
        cfg_write(ssc_pkg::CFG_NEEDLE_HIGH, hi);
        i_cfg_wr_en <= 1'b0;
    endtask

    // letters a-d in both cases, the bytes around A-Z and a-z, or anything
    function automatic logic [7:0] needle_char();
        logic [7:0] ch;
        int         pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            return 8'($urandom_range(0, 255));
        end
        if (pick == 2) begin
            case ($urandom_range(0, 3))
                0: ch = ssc_pkg::UPPER_FIRST - 8'd1;
                1: ch = ssc_pkg::UPPER_FIRST;
                2: ch = ssc_pkg::UPPER_LAST;
                default: ch = ssc_pkg::UPPER_LAST + 8'd1;
            endcase
            if ($urandom_range(0, 1) == 1) ch = ch + ssc_pkg::FOLD_DELTA;
            return ch;
        end
        ch = ssc_pkg::UPPER_FIRST + ssc_pkg::FOLD_DELTA + 8'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 1) ch = ch - ssc_pkg::FOLD_DELTA;
        return ch;
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] b);
        bit letter;
        letter = (b >= ssc_pkg::UPPER_FIRST && b <= ssc_pkg::UPPER_LAST) ||
                 (b >= ssc_pkg::UPPER_FIRST + ssc_pkg::FOLD_DELTA &&
                  b <= ssc_pkg::UPPER_LAST + ssc_pkg::FOLD_DELTA);
        if (letter && $urandom_range(0, cfg_fold ? 1 : 9) == 0) begin
            return b ^ ssc_pkg::FOLD_DELTA;
        end
        return b;
    endfunction

    function automatic logic [7:0] hay_byte();
        int span;
        int pick;
        span = needle_span();
        pick = $urandom_range(0, 9);
        if (pick < 5 && span > 0) begin
            return flip_case(needle_at($urandom_range(0, span - 1)));
        end
        if (pick < 8) begin
            return needle_char();
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_haystack(input int n, input bit plant);
        logic [7:0] hay [$];
        int         span;
        int         pos;
        span = needle_span();
        for (int k = 0; k < n; k++) hay.push_back(hay_byte());
        if (plant && span > 0 && n >= span) begin
            pos = $urandom_range(0, n - span);
            for (int k = 0; k < span; k++) hay[pos + k] = flip_case(needle_at(k));
        end
        for (int k = 0; k < n; k++) send_byte(hay[k], k == n - 1);
    endtask

    task automatic load_random_search();
        int          len;
        logic [63:0] lo;
        logic [63:0] hi;
        case ($urandom_range(0, 9))
            0: len = 0;
            1: len = NEEDLE_MAX;
            2: len = $urandom_range(NEEDLE_MAX + 1, 31);
            3: len = $urandom_range(7, NEEDLE_MAX - 1);
            default: len = $urandom_range(1, 6);
        endcase
        for (int k = 0; k < 8; k++) begin
            lo[8*k +: 8] = needle_char();
            hi[8*k +: 8] = needle_char();
        end
        if ($urandom_range(0, 7) == 0) lo = {$urandom, $urandom};
        if ($urandom_range(0, 7) == 0) hi = {$urandom, $urandom};
        load_search(len, $urandom_range(0, 1), lo, hi);
    endtask

    function automatic int random_hay_len();
        case ($urandom_range(0, 9))
            0: return 1;
            1, 2: return $urandom_range(NEEDLE_MAX, 48);
            default: return $urandom_range(2, 20);
        endcase
    endfunction

    task automatic test_empty_needle();
        load_search(0, 1'b0, {$urandom, $urandom}, {$urandom, $urandom});
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        drain();
    endtask

    task automatic test_short_haystack();
        load_search(3, 1'b0, 64'h636261, '0);
        send_text("ab");
        drain();
    endtask

    task automatic test_case_fold();
        load_search(2, 1'b0, 64'h5A41, '0);
        send_text("az");
        send_text("xAZ");
        drain();
        load_search(2, 1'b1, 64'h5A41, '0);
        send_text("az");
        drain();
        // '@' and '[' sit just outside A-Z and must not fold
        load_search(2, 1'b1, 64'h5B40, '0);
        send_byte(8'h60, 1'b0);
        send_byte(8'h7B, 1'b1);
        drain();
    endtask

    // a length above the window is clamped to the full window
    task automatic test_needle_clamp();
        load_search(31, 1'b1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        for (int k = 0; k < NEEDLE_MAX; k++) send_byte(needle_at(k), k == NEEDLE_MAX - 1);
        drain();
    endtask

    task automatic test_random_search();
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            src_idle = ($urandom_range(0, 3) != 0);
            snk_idle = ($urandom_range(0, 3) != 0);
            load_random_search();
            repeat ($urandom_range(3, 8)) begin
                send_haystack(random_hay_len(), $urandom_range(0, 9) < 6);
            end
            drain();
        end
    endtask

    // output held off while short haystacks keep coming, so the input stalls
    task automatic test_backpressure();
        src_idle = 1'b0;
        snk_idle = 1'b0;
        load_search(1, 1'b1, 64'h61, '0);
        hold_req = 150;
        repeat (40) send_haystack($urandom_range(1, 3), $urandom_range(0, 1));
        drain();
    endtask

    task automatic test_steady_stream();
        int start;
        src_idle = 1'b0;
        snk_idle = 1'b0;
        start    = items_sent;
        while (items_sent - start < STEADY_ITEMS) begin
            load_random_search();
            repeat ($urandom_range(3, 6)) begin
                send_haystack(random_hay_len(), $urandom_range(0, 9) < 6);
            end
            drain();
        end
    endtask

    initial begin
        clear_haystack();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_needle();
        test_short_haystack();
        test_case_fold();
        test_needle_clamp();
        test_random_search();
        test_backpressure();
        test_steady_stream();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
